@@ hw/rtl/isdt_pkg.sv @@
// ----------------------------------------------------------------------------
// isdt_pkg
// shared types and constants of the i2s sample dc tracker
// ----------------------------------------------------------------------------
package isdt_pkg;

    localparam int SLOT_W       = 32;
    localparam int SAMPLE_SHIFT = 14;
    localparam int RAW_W        = SLOT_W - SAMPLE_SHIFT;
    localparam int SMP_W        = 16;
    localparam int BAL_W        = 11;
    localparam int LEN_W        = 11;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    localparam logic signed [RAW_W:0]   CLAMP_HI     = 19'sd32767;
    localparam logic signed [RAW_W:0]   CLAMP_LO     = -19'sd32767;
    localparam logic signed [RAW_W-1:0] OFFSET_RESET = -18'sd8192;
    localparam logic signed [RAW_W-1:0] OFFSET_HI    = 18'sd131071;
    localparam logic signed [RAW_W-1:0] OFFSET_LO    = -18'sd131072;
    localparam logic signed [BAL_W-1:0] BAL_HI       = 11'sd1023;
    localparam logic signed [BAL_W-1:0] BAL_LO       = -11'sd1024;
    localparam logic [LEN_W-1:0]        BLOCK_LEN_RESET = 11'd256;

    // register index, taken from paddr above the byte offset
    localparam logic REG_BLOCK_LENGTH = 1'b0;

    typedef struct packed {
        logic signed [RAW_W-1:0] offset_now;
        logic signed [SMP_W-1:0] block_max;
        logic signed [SMP_W-1:0] block_min;
        logic                    block_end;
        logic signed [SMP_W-1:0] sample_out;
    } result_t;

    typedef struct packed {
        logic signed [RAW_W-1:0] offset;
        logic                    count_zero;
    } track_status_t;

endpackage

@@ hw/rtl/isdt_sample.sv @@
// ----------------------------------------------------------------------------
// isdt_sample
// slot to sample extraction, offset removal and symmetric clamp
// ----------------------------------------------------------------------------
module isdt_sample
(
    input  logic [15:0]                            high_half,
    input  logic [15:0]                            low_half,
    input  logic signed [isdt_pkg::RAW_W-1:0]      offset,
    output logic signed [isdt_pkg::SMP_W-1:0]      sample
);

    logic [isdt_pkg::SLOT_W-1:0]          slot;
    logic signed [isdt_pkg::RAW_W-1:0]    raw;
    logic signed [isdt_pkg::RAW_W:0]      diff;

    assign slot = {high_half, low_half};
    assign raw  = $signed(slot[isdt_pkg::SLOT_W-1:isdt_pkg::SAMPLE_SHIFT]);
    assign diff = {raw[isdt_pkg::RAW_W-1], raw} - {offset[isdt_pkg::RAW_W-1], offset};

    always_comb
    begin
        if (diff > isdt_pkg::CLAMP_HI)
        begin
            sample = isdt_pkg::CLAMP_HI[isdt_pkg::SMP_W-1:0];
        end
        else if (diff < isdt_pkg::CLAMP_LO)
        begin
            sample = isdt_pkg::CLAMP_LO[isdt_pkg::SMP_W-1:0];
        end
        else
        begin
            sample = diff[isdt_pkg::SMP_W-1:0];
        end
    end

endmodule

@@ hw/rtl/isdt_track.sv @@
// ----------------------------------------------------------------------------
// isdt_track
// block statistics: running min/max, sign balance, sample count and offset
// ----------------------------------------------------------------------------
module isdt_track
#(
    parameter int MAX_BLOCK = 1024
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic signed [isdt_pkg::SMP_W-1:0]    sample,
    input  logic [isdt_pkg::LEN_W-1:0]           block_length,
    output isdt_pkg::result_t                    result,
    output isdt_pkg::track_status_t              status
);

    localparam int CNT_W = $clog2(MAX_BLOCK);
    localparam int CMP_W = (CNT_W + 1 > isdt_pkg::LEN_W) ? CNT_W + 1 : isdt_pkg::LEN_W;
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_BLOCK);
    localparam logic [CMP_W-1:0] ONE_LEN = CMP_W'(1);

    logic signed [isdt_pkg::RAW_W-1:0]  offset_reg, offset_next;
    logic signed [isdt_pkg::SMP_W-1:0]  min_reg, min_next, min_upd;
    logic signed [isdt_pkg::SMP_W-1:0]  max_reg, max_next, max_upd;
    logic signed [isdt_pkg::BAL_W-1:0]  bal_reg, bal_next, bal_upd;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [CNT_W:0]                     count_inc;
    logic [CMP_W-1:0]                   len_ext, eff_len;
    logic                               reseed, is_pos, is_neg, block_end;
    logic signed [isdt_pkg::RAW_W-1:0]  offset_step;

    always_comb
    begin
        reseed = (min_reg == '0) && (max_reg == '0);
        if (reseed)
        begin
            min_upd = sample;
            max_upd = sample;
        end
        else
        begin
            min_upd = (sample < min_reg) ? sample : min_reg;
            max_upd = (sample > max_reg) ? sample : max_reg;
        end

        is_neg = sample[isdt_pkg::SMP_W-1];
        is_pos = !is_neg && (sample != '0);
        bal_upd = bal_reg;
        if (is_pos && (bal_reg < isdt_pkg::BAL_HI))
        begin
            bal_upd = bal_reg + isdt_pkg::BAL_W'(1);
        end
        if (is_neg && (bal_reg > isdt_pkg::BAL_LO))
        begin
            bal_upd = bal_reg - isdt_pkg::BAL_W'(1);
        end

        len_ext = CMP_W'(block_length);
        if (len_ext == '0)
        begin
            eff_len = ONE_LEN;
        end
        else if (len_ext > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = len_ext;
        end

        count_inc = {1'b0, count_reg} + (CNT_W + 1)'(1);
        block_end = CMP_W'(count_inc) >= eff_len;

        // one step toward balance at block end
        offset_step = offset_reg;
        if ((bal_upd > 0) && (offset_reg < isdt_pkg::OFFSET_HI))
        begin
            offset_step = offset_reg + isdt_pkg::RAW_W'(1);
        end
        if ((bal_upd < 0) && (offset_reg > isdt_pkg::OFFSET_LO))
        begin
            offset_step = offset_reg - isdt_pkg::RAW_W'(1);
        end

        if (block_end)
        begin
            offset_next = offset_step;
            min_next    = '0;
            max_next    = '0;
            bal_next    = '0;
            count_next  = '0;
        end
        else
        begin
            offset_next = offset_reg;
            min_next    = min_upd;
            max_next    = max_upd;
            bal_next    = bal_upd;
            count_next  = count_inc[CNT_W-1:0];
        end

        result.sample_out = sample;
        result.block_end  = block_end;
        result.block_min  = block_end ? min_upd : '0;
        result.block_max  = block_end ? max_upd : '0;
        result.offset_now = offset_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= isdt_pkg::OFFSET_RESET;
            min_reg    <= '0;
            max_reg    <= '0;
            bal_reg    <= '0;
            count_reg  <= '0;
        end
        else if (load)
        begin
            offset_reg <= offset_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            bal_reg    <= bal_next;
            count_reg  <= count_next;
        end
    end

    assign status.offset     = offset_reg;
    assign status.count_zero = (count_reg == '0);

endmodule

@@ hw/rtl/i2s_sample_dc_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// i2s_sample_dc_tracker_unit
// i2s slot sample extraction with tracked dc offset removal and block min/max
//
// channel   | direction | handshake                | payload
// s_axis    | in        | tvalid / tready          | tdata: slot halves
// m_axis    | out       | tvalid / tready, tlast   | tdata: sample, min, max, offset
// apb       | in        | psel / penable / pready  | block_length at address 0
//
// one transaction per cycle unless m_axis stalls; the path from input to result is
// the input register, then statistics update and result register
// all state is updated in the same cycle that loads the result register
// a stall on m_axis holds both stages; s_axis_tready is high when the input register is empty or advances
// reset: offset -8192, statistics clear, block_length 256
// ----------------------------------------------------------------------------
module i2s_sample_dc_tracker_unit
#(
    parameter int MAX_BLOCK = 1024
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [31:0]                          s_axis_tdata,  // high_half, low_half
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [71:0]                          m_axis_tdata,  // sample_out, block_min, block_max, offset_now
    output logic                                 m_axis_tlast,  // block_end
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [isdt_pkg::ADDR_W-1:0]          paddr,
    input  logic [isdt_pkg::DATA_W-1:0]          pwdata,
    output logic [isdt_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    logic                          in_valid_reg;
    logic [15:0]                   high_reg;
    logic [15:0]                   low_reg;
    logic                          out_valid_reg;
    isdt_pkg::result_t             out_reg;
    logic [isdt_pkg::LEN_W-1:0]    block_length_reg;
    logic                          advance, load;
    logic signed [isdt_pkg::SMP_W-1:0] sample;
    isdt_pkg::result_t             result;
    isdt_pkg::track_status_t       status;

    assign pready  = 1'b1;
    assign advance = !out_valid_reg || m_axis_tready;
    assign load    = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        unique case (paddr[isdt_pkg::ADDR_W-1])
            isdt_pkg::REG_BLOCK_LENGTH: prdata = isdt_pkg::DATA_W'(block_length_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= isdt_pkg::BLOCK_LEN_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[isdt_pkg::ADDR_W-1] == isdt_pkg::REG_BLOCK_LENGTH))
        begin
            block_length_reg <= pwdata[isdt_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            high_reg <= s_axis_tdata[15:0];
            low_reg  <= s_axis_tdata[31:16];
        end
        if (load)
        begin
            out_reg <= result;
        end
    end

    isdt_sample u_sample
    (
        .high_half (high_reg),
        .low_half  (low_reg),
        .offset    (status.offset),
        .sample    (sample)
    );

    isdt_track
    #(
        .MAX_BLOCK (MAX_BLOCK)
    )
    u_track
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .sample       (sample),
        .block_length (block_length_reg),
        .result       (result),
        .status       (status)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_reg.block_end;
    assign m_axis_tdata  = {6'b0, out_reg.offset_now, out_reg.block_max,
                            out_reg.block_min, out_reg.sample_out};

`ifndef NO_ASSERTIONS
    // offset moves only on a block-closing transaction
    a_offset_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(load && result.block_end) |=> $stable(status.offset))
        else $error("offset changed outside block end");

    // a block end restarts the sample count
    a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (load && result.block_end) |=> status.count_zero)
        else $error("sample count not cleared at block end");

    // an empty result register never blocks the input
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");
`endif

endmodule
